// ===== hw/rtl/rhsv_pkg.sv =====
// Package for the RGB to HSV converter.
// Holds the hue sector type and the width constant HUE_EXTRA used by the design modules.
package rhsv_pkg;
   // Extra bits that the hue divisor needs on top of a sample, since it is six times chroma.
   localparam int HUE_EXTRA = 3;

   typedef enum logic [1:0] {
      SEC_RED,
      SEC_GREEN,
      SEC_BLUE
   } sector_type;
endpackage

// ===== hw/rtl/rhsv_front.sv =====
// Front end of the RGB to HSV converter: max, min, chroma and divider operands.
// Two register stages. Depends on rhsv_pkg.
module rhsv_front import rhsv_pkg::*; #(
   parameter int N = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [N-1:0]           red,
   input  logic [N-1:0]           green,
   input  logic [N-1:0]           blue,
   output logic                   out_valid,
   output logic [N+HUE_EXTRA-1:0] hue_rem,
   output logic [N+HUE_EXTRA-1:0] hue_den,
   output logic [N-1:0]           sat_rem,
   output logic [N-1:0]           sat_den,
   output logic [N-1:0]           sat_low,
   output logic [N-1:0]           value
);
   localparam int DW = N + HUE_EXTRA + 1;

   logic              a_valid_ff, a_valid_in;
   logic [N-1:0]      a_v_ff, a_v_in, a_c_ff, a_c_in, mn;
   logic signed [DW-1:0] a_diff_ff, a_diff_in;
   sector_type        a_sec_ff, a_sec_in;

   logic              b_valid_ff;
   logic [N+HUE_EXTRA-1:0] b_rem_ff, b_rem_in, b_den_ff, b_den_in;
   logic [N-1:0]      b_srem_ff, b_srem_in, b_sden_ff, b_sden_in, b_slow_ff, b_slow_in;
   logic [N-1:0]      b_v_ff;
   logic signed [DW-1:0] pos, six_c;
   logic [2*N-1:0]    prod;

   always_comb begin
      a_valid_in = in_valid;
      a_v_in = red;
      if (green > a_v_in) a_v_in = green;
      if (blue > a_v_in) a_v_in = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      a_c_in = a_v_in - mn;
      if (a_v_in == red) begin
         a_sec_in  = SEC_RED;
         a_diff_in = $signed({{(DW-N){1'b0}}, green}) - $signed({{(DW-N){1'b0}}, blue});
      end else if (a_v_in == green) begin
         a_sec_in  = SEC_GREEN;
         a_diff_in = $signed({{(DW-N){1'b0}}, blue}) - $signed({{(DW-N){1'b0}}, red});
      end else begin
         a_sec_in  = SEC_BLUE;
         a_diff_in = $signed({{(DW-N){1'b0}}, red}) - $signed({{(DW-N){1'b0}}, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
      a_v_ff    <= a_v_in;
      a_c_ff    <= a_c_in;
      a_diff_ff <= a_diff_in;
      a_sec_ff  <= a_sec_in;
      b_rem_ff  <= b_rem_in;
      b_den_ff  <= b_den_in;
      b_srem_ff <= b_srem_in;
      b_sden_ff <= b_sden_in;
      b_slow_ff <= b_slow_in;
      b_v_ff    <= a_v_ff;
   end

   always_comb begin
      six_c = $signed({{(DW-N){1'b0}}, a_c_ff} <<< 2) + $signed({{(DW-N){1'b0}}, a_c_ff} <<< 1);
      case (a_sec_ff)
         SEC_GREEN: pos = a_diff_ff + $signed({{(DW-N){1'b0}}, a_c_ff} <<< 1);
         SEC_BLUE:  pos = a_diff_ff + $signed({{(DW-N){1'b0}}, a_c_ff} <<< 2);
         default:   pos = a_diff_ff;
      endcase
      if (pos < 0) pos = pos + six_c;
      if (pos >= six_c) pos = pos - six_c;
      // A gray pixel gets an all-ones divisor so that every quotient bit comes out zero.
      if (a_c_ff == '0) begin
         b_rem_in = '0;
         b_den_in = '1;
      end else begin
         b_rem_in = pos[N+HUE_EXTRA-1:0];
         b_den_in = six_c[N+HUE_EXTRA-1:0];
      end
      // Chroma times full scale, formed as a shift and a subtract.
      prod = {a_c_ff, {N{1'b0}}} - {{N{1'b0}}, a_c_ff};
      b_srem_in = prod[2*N-1:N];
      b_slow_in = prod[N-1:0];
      b_sden_in = (a_v_ff == '0) ? '1 : a_v_ff;
   end

   assign out_valid = b_valid_ff;
   assign hue_rem   = b_rem_ff;
   assign hue_den   = b_den_ff;
   assign sat_rem   = b_srem_ff;
   assign sat_den   = b_sden_ff;
   assign sat_low   = b_slow_ff;
   assign value     = b_v_ff;
endmodule

// ===== hw/rtl/rhsv_div_cell.sv =====
// One cell of the divider chain: one quotient bit of hue and of saturation per beat.
// Depends on rhsv_pkg.
module rhsv_div_cell import rhsv_pkg::*; #(
   parameter int N = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [N+HUE_EXTRA-1:0] in_hrem,
   input  logic [N+HUE_EXTRA-1:0] in_hden,
   input  logic [N-1:0]           in_hq,
   input  logic [N-1:0]           in_srem,
   input  logic [N-1:0]           in_sden,
   input  logic [N-1:0]           in_slow,
   input  logic [N-1:0]           in_sq,
   input  logic [N-1:0]           in_value,
   output logic                   out_valid,
   output logic [N+HUE_EXTRA-1:0] out_hrem,
   output logic [N+HUE_EXTRA-1:0] out_hden,
   output logic [N-1:0]           out_hq,
   output logic [N-1:0]           out_srem,
   output logic [N-1:0]           out_sden,
   output logic [N-1:0]           out_slow,
   output logic [N-1:0]           out_sq,
   output logic [N-1:0]           out_value
);
   logic                   valid_ff;
   logic [N+HUE_EXTRA-1:0] hrem_ff, hrem_in, hden_ff;
   logic [N-1:0]           hq_ff, hq_in, srem_ff, srem_in, sden_ff, slow_ff, sq_ff, sq_in, value_ff;
   logic [N+HUE_EXTRA:0]   htry;
   logic [N:0]             stry;

   always_comb begin
      htry = {in_hrem, 1'b0};
      if (htry >= {1'b0, in_hden}) begin
         htry  = htry - {1'b0, in_hden};
         hq_in = {in_hq[N-2:0], 1'b1};
      end else begin
         hq_in = {in_hq[N-2:0], 1'b0};
      end
      hrem_in = htry[N+HUE_EXTRA-1:0];
      stry = {in_srem, in_slow[N-1]};
      if (stry >= {1'b0, in_sden}) begin
         stry  = stry - {1'b0, in_sden};
         sq_in = {in_sq[N-2:0], 1'b1};
      end else begin
         sq_in = {in_sq[N-2:0], 1'b0};
      end
      srem_in = stry[N-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      hrem_ff  <= hrem_in;
      hden_ff  <= in_hden;
      hq_ff    <= hq_in;
      srem_ff  <= srem_in;
      sden_ff  <= in_sden;
      slow_ff  <= {in_slow[N-2:0], 1'b0};
      sq_ff    <= sq_in;
      value_ff <= in_value;
   end

   assign out_valid = valid_ff;
   assign out_hrem  = hrem_ff;
   assign out_hden  = hden_ff;
   assign out_hq    = hq_ff;
   assign out_srem  = srem_ff;
   assign out_sden  = sden_ff;
   assign out_slow  = slow_ff;
   assign out_sq    = sq_ff;
   assign out_value = value_ff;
endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter.
// Instantiates rhsv_front and a chain of rhsv_div_cell. Depends on rhsv_pkg.
//
// One pixel is taken in every cycle and busy stays low. Each result appears
// for one cycle, with rsp_valid high, once its pixel has passed two front
// stages that find value and chroma and one divider cell per quotient bit
// that forms hue and saturation. The receiver cannot stall the chain.
module rgb_to_hsv_converter import rhsv_pkg::*; #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [PIXEL_BITS-1:0] req_red,
   input  logic [PIXEL_BITS-1:0] req_green,
   input  logic [PIXEL_BITS-1:0] req_blue,
   output logic                  rsp_valid,
   output logic [PIXEL_BITS-1:0] rsp_hue,
   output logic [PIXEL_BITS-1:0] rsp_saturation,
   output logic [PIXEL_BITS-1:0] rsp_value
);
   localparam int N = PIXEL_BITS;

   logic                   valid  [N+1];
   logic [N+HUE_EXTRA-1:0] hrem   [N+1];
   logic [N+HUE_EXTRA-1:0] hden   [N+1];
   logic [N-1:0]           hq     [N+1];
   logic [N-1:0]           srem   [N+1];
   logic [N-1:0]           sden   [N+1];
   logic [N-1:0]           slow   [N+1];
   logic [N-1:0]           sq     [N+1];
   logic [N-1:0]           val    [N+1];

   assign busy  = 1'b0;
   assign hq[0] = '0;
   assign sq[0] = '0;

   rhsv_front #(.N(N)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (valid[0]),
      .hue_rem   (hrem[0]),
      .hue_den   (hden[0]),
      .sat_rem   (srem[0]),
      .sat_den   (sden[0]),
      .sat_low   (slow[0]),
      .value     (val[0])
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      rhsv_div_cell #(.N(N)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_hrem   (hrem[i]),
         .in_hden   (hden[i]),
         .in_hq     (hq[i]),
         .in_srem   (srem[i]),
         .in_sden   (sden[i]),
         .in_slow   (slow[i]),
         .in_sq     (sq[i]),
         .in_value  (val[i]),
         .out_valid (valid[i+1]),
         .out_hrem  (hrem[i+1]),
         .out_hden  (hden[i+1]),
         .out_hq    (hq[i+1]),
         .out_srem  (srem[i+1]),
         .out_sden  (sden[i+1]),
         .out_slow  (slow[i+1]),
         .out_sq    (sq[i+1]),
         .out_value (val[i+1])
      );
   end

   assign rsp_valid      = valid[N];
   assign rsp_hue        = hq[N];
   assign rsp_saturation = sq[N];
   assign rsp_value      = val[N];
endmodule

// ===== tb/rgb_to_hsv_checker.sv =====
// Checker for the RGB to HSV converter: watches the pixel and result channels,
// computes the expected hue, saturation and value, and counts mismatches.
// Depends on nothing but the ports of rgb_to_hsv_converter.
`timescale 1ns / 100ps
module rgb_to_hsv_checker #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic [PIXEL_BITS-1:0] req_red,
   input  logic [PIXEL_BITS-1:0] req_green,
   input  logic [PIXEL_BITS-1:0] req_blue,
   input  logic                  rsp_valid,
   input  logic [PIXEL_BITS-1:0] rsp_hue,
   input  logic [PIXEL_BITS-1:0] rsp_saturation,
   input  logic [PIXEL_BITS-1:0] rsp_value,
   output int                    fail_count,
   output int                    pending
);
   typedef struct packed {
      logic [PIXEL_BITS-1:0] hue;
      logic [PIXEL_BITS-1:0] sat;
      logic [PIXEL_BITS-1:0] val;
   } hsv_type;

   hsv_type hsv_queue[$];

   function automatic hsv_type convert_pixel(logic [PIXEL_BITS-1:0] r,
                                             logic [PIXEL_BITS-1:0] g,
                                             logic [PIXEL_BITS-1:0] b);
      hsv_type res;
      longint mx, mn, c, pos, six_c, fs;
      longint unsigned rem, q;
      fs = (64'd1 << PIXEL_BITS) - 1;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      c = mx - mn;
      res.val = PIXEL_BITS'(mx);
      res.sat = (mx == 0) ? '0 : PIXEL_BITS'((c * fs) / mx);
      res.hue = '0;
      if (c != 0) begin
         if (mx == r) pos = longint'(g) - longint'(b);
         else if (mx == g) pos = 2 * c + longint'(b) - longint'(r);
         else pos = 4 * c + longint'(r) - longint'(g);
         six_c = 6 * c;
         if (pos < 0) pos += six_c;
         if (pos >= six_c) pos -= six_c;
         rem = pos;
         q = 0;
         for (int i = 0; i < PIXEL_BITS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= six_c) begin
               rem -= six_c;
               q |= 1;
            end
         end
         res.hue = PIXEL_BITS'(q);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      hsv_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_valid) begin
            if (hsv_queue.size() == 0) begin
               $error("result beat with nothing expected");
               errs++;
            end else begin
               want = hsv_queue.pop_front();
               if (rsp_hue !== want.hue) begin
                  $error("hue: expected %0d, got %0d", want.hue, rsp_hue);
                  errs++;
               end
               if (rsp_saturation !== want.sat) begin
                  $error("saturation: expected %0d, got %0d", want.sat, rsp_saturation);
                  errs++;
               end
               if (rsp_value !== want.val) begin
                  $error("value: expected %0d, got %0d", want.val, rsp_value);
                  errs++;
               end
            end
         end
         if (start && !busy) hsv_queue.push_back(convert_pixel(req_red, req_green, req_blue));
         fail_count <= fail_count + errs;
         pending <= hsv_queue.size();
      end
   end
endmodule

// ===== tb/tb_rgb_to_hsv_converter.sv =====
// Testbench top for the RGB to HSV converter: drives directed and random
// pixels in bursts and gives the verdict. Uses rgb_to_hsv_checker.
`timescale 1ns / 100ps
module tb_rgb_to_hsv_converter;
   localparam int PB = 16;
   localparam logic [PB-1:0] FS = '1;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [PB-1:0] req_red = '0, req_green = '0, req_blue = '0;
   logic rsp_valid;
   logic [PB-1:0] rsp_hue, rsp_saturation, rsp_value;
   int fail_count, pending;
   int cycles = 0;

   rgb_to_hsv_converter #(.PIXEL_BITS(PB)) dut (.*);
   rgb_to_hsv_checker #(.PIXEL_BITS(PB)) checker_inst (.*);

   initial forever #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("tb_rgb_to_hsv_converter: FAIL");
         $finish;
      end
   end

   task automatic send_pixel(logic [PB-1:0] r, logic [PB-1:0] g, logic [PB-1:0] b);
      start <= 1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic pause_cycles(int n);
      start <= 0;
      repeat (n) @(posedge clock);
   endtask

   function automatic logic [PB-1:0] rand_sample();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return FS;
         2: return PB'($urandom_range(0, 15));
         3: return FS - PB'($urandom_range(0, 15));
         default: return PB'($urandom());
      endcase
   endfunction

   initial begin
      logic [PB-1:0] a, b2;
      int burst;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_pixel(0, 0, 0);
      send_pixel(FS, FS, FS);
      send_pixel(16'h1234, 16'h1234, 16'h1234);
      send_pixel(FS, 0, 0);
      send_pixel(0, FS, 0);
      send_pixel(0, 0, FS);
      send_pixel(FS, FS, 0);
      send_pixel(0, FS, FS);
      send_pixel(FS, 0, FS);
      send_pixel(FS, 0, 1);
      send_pixel(1, 0, 0);
      send_pixel(0, 1, 0);
      send_pixel(0, 0, 1);
      send_pixel(FS, FS - 1, 0);
      send_pixel(FS, 16'hAAAA, 16'h5555);
      send_pixel(16'h5555, 16'hAAAA, 16'hAAAA);
      send_pixel(1, 2, 3);
      pause_cycles(1);
      while (pending != 0) @(posedge clock);
      for (int n = 0; n < 950; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst; k++, n++) begin
            a = rand_sample();
            b2 = rand_sample();
            case ($urandom_range(0, 4))
               0: send_pixel(a, a, b2);
               1: send_pixel(b2, a, a);
               2: send_pixel(a, b2, a);
               default: send_pixel(a, b2, rand_sample());
            endcase
         end
         if ($urandom_range(0, 2) != 0) pause_cycles($urandom_range(1, 25));
      end
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (PB + 10) @(posedge clock);
      if (fail_count == 0 && !rsp_valid)
         $display("tb_rgb_to_hsv_converter: PASS");
      else
         $display("tb_rgb_to_hsv_converter: FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/rhsv_pkg.sv
hw/rtl/rhsv_front.sv
hw/rtl/rhsv_div_cell.sv
hw/rtl/rgb_to_hsv_converter.sv
tb/rgb_to_hsv_checker.sv
tb/tb_rgb_to_hsv_converter.sv
